[design/mbg_pkg.sv]
// ----------------------------------------------------------------------------
// mbg_pkg
// Shared constants, codes and controller/datapath types for the maze
// backtracker generator.
// ----------------------------------------------------------------------------
package mbg_pkg;

  localparam int unsigned MaxCellsDef = 1024;
  localparam int unsigned MaxSideDef  = 32;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned KindW    = 2;
  localparam int unsigned RandW    = 16;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned DirW     = 2;
  localparam int unsigned PathW    = 4;
  localparam int unsigned CellBits = 5;
  localparam int unsigned VisitedBit = 4;

  localparam logic [CellBits-1:0] VisitedMask = 5'b10000;
  localparam logic [CfgDataW-1:0] GridSideReset = 6'd5;

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 2'd1;

  localparam logic [KindW-1:0] KindStart = 2'd0;
  localparam logic [KindW-1:0] KindCarve = 2'd1;
  localparam logic [KindW-1:0] KindQuery = 2'd2;

  localparam logic [DirW-1:0] DirNorth = 2'd0;
  localparam logic [DirW-1:0] DirSouth = 2'd1;
  localparam logic [DirW-1:0] DirEast  = 2'd2;
  localparam logic [DirW-1:0] DirWest  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SZ_MUL,
    ST_SZ_CHK,
    ST_CLEAR,
    ST_INIT,
    ST_C_TOP,
    ST_C_CUR,
    ST_C_RDC,
    ST_C_NB,
    ST_C_NWT,
    ST_C_SEL,
    ST_C_PUSH,
    ST_Q_RD,
    ST_Q_CAP,
    ST_FINISH
  } mbg_state_e;

  typedef struct packed {
    logic accept;
    logic size_load;
    logic size_mul;
    logic h_dec;
    logic total_load;
    logic clr_step;
    logic init;
    logic stk_rd;
    logic cur_load;
    logic rd_cur;
    logic rd_nb;
    logic pop;
    logic sel;
    logic push;
    logic q_rd;
    logic q_cap;
    logic out_load;
  } mbg_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_carve;
    logic is_query;
    logic carve_ok;
    logic query_ok;
    logic prod_fits;
    logic clr_last;
    logic depth_zero;
    logic nb_last;
    logic nb_none;
  } mbg_status_t;

endpackage

[design/mbg_ram.sv]
// ----------------------------------------------------------------------------
// mbg_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mbg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mbg_ctrl.sv]
// ----------------------------------------------------------------------------
// mbg_ctrl
// Controller: sequences start, carve and query items and the result register.
// ----------------------------------------------------------------------------
module mbg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mbg_pkg::mbg_status_t status_i,
  output mbg_pkg::mbg_cmd_t    cmd_o
);
  import mbg_pkg::*;

  mbg_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  mbg_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (status_i.is_start) begin
          cmd.size_load = 1'b1;
          state_d       = ST_SZ_MUL;
        end else if (status_i.is_carve) begin
          state_d = status_i.carve_ok ? ST_C_TOP : ST_FINISH;
        end else if (status_i.is_query) begin
          state_d = status_i.query_ok ? ST_Q_RD : ST_FINISH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SZ_MUL: begin
        cmd.size_mul = 1'b1;
        state_d      = ST_SZ_CHK;
      end
      ST_SZ_CHK: begin
        if (status_i.prod_fits) begin
          cmd.total_load = 1'b1;
          state_d        = ST_CLEAR;
        end else begin
          cmd.h_dec = 1'b1;
          state_d   = ST_SZ_MUL;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        state_d  = ST_FINISH;
      end
      ST_C_TOP: begin
        if (status_i.depth_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd.stk_rd = 1'b1;
          state_d    = ST_C_CUR;
        end
      end
      ST_C_CUR: begin
        cmd.cur_load = 1'b1;
        state_d      = ST_C_RDC;
      end
      ST_C_RDC: begin
        cmd.rd_cur = 1'b1;
        state_d    = ST_C_NB;
      end
      ST_C_NB: begin
        cmd.rd_nb = 1'b1;
        if (status_i.nb_last) begin
          state_d = ST_C_NWT;
        end
      end
      ST_C_NWT: begin
        state_d = ST_C_SEL;
      end
      ST_C_SEL: begin
        if (status_i.nb_none) begin
          cmd.pop = 1'b1;
          state_d = ST_C_TOP;
        end else begin
          cmd.sel = 1'b1;
          state_d = ST_C_PUSH;
        end
      end
      ST_C_PUSH: begin
        cmd.push = 1'b1;
        state_d  = ST_FINISH;
      end
      ST_Q_RD: begin
        cmd.q_rd = 1'b1;
        state_d  = ST_Q_CAP;
      end
      ST_Q_CAP: begin
        cmd.q_cap = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[design/mbg_dp.sv]
// ----------------------------------------------------------------------------
// mbg_dp
// Datapath: grid size registers, cell store, path stack, neighbour scan,
// move selection and the result register.
// ----------------------------------------------------------------------------
module mbg_dp #(
  parameter int unsigned MaxCells = mbg_pkg::MaxCellsDef,
  parameter int unsigned MaxSide  = mbg_pkg::MaxSideDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [mbg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mbg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [mbg_pkg::KindW-1:0]     kind_i,
  input  logic [mbg_pkg::RandW-1:0]     random_word_i,
  input  logic [mbg_pkg::IdxW-1:0]      query_cell_i,
  input  logic [mbg_pkg::DirW-1:0]      query_action_i,
  input  mbg_pkg::mbg_cmd_t             cmd_i,
  output mbg_pkg::mbg_status_t          status_o,
  output logic [mbg_pkg::IdxW-1:0]      from_cell_o,
  output logic [mbg_pkg::IdxW-1:0]      to_cell_o,
  output logic [mbg_pkg::DirW-1:0]      carve_dir_o,
  output logic                          carved_o,
  output logic                          done_res_o,
  output logic [mbg_pkg::PathW-1:0]     cell_paths_o,
  output logic                          action_open_o,
  output logic                          cell_valid_o
);
  import mbg_pkg::*;

  localparam int unsigned CellW  = $clog2(MaxCells);
  localparam int unsigned SideW  = $clog2(MaxSide + 1);
  localparam int unsigned CoordW = $clog2(MaxSide);
  localparam int unsigned CntW   = CellW + 1;
  localparam int unsigned ProdW  = (2 * SideW > CntW) ? 2 * SideW : CntW;
  localparam int unsigned CmpW   = (CntW > IdxW) ? CntW : IdxW;
  localparam int unsigned StkW   = CellW + 2 * CoordW;

  function automatic logic [SideW-1:0] clamp_side(input logic [CfgDataW-1:0] v,
                                                  input logic is_width);
    int unsigned r;
    r = 32'(v);
    if (r < 2) r = 2;
    if (r > MaxSide) r = MaxSide;
    if (is_width && r > MaxCells) r = MaxCells;
    return SideW'(r);
  endfunction

  function automatic logic [1:0] mod3(input logic [RandW-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] r;
    s = '0;
    for (int i = 0; i < RandW / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    unique case (t)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [DirW-1:0] pick(input logic [3:0] avail, input logic [1:0] k);
    logic [2:0]      cnt;
    logic [DirW-1:0] d;
    logic            found;
    cnt   = '0;
    d     = DirNorth;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (avail[i]) begin
        if (!found && cnt == 3'(k)) begin
          d     = DirW'(i);
          found = 1'b1;
        end
        cnt = cnt + 3'd1;
      end
    end
    return d;
  endfunction

  // configuration and latched item
  logic [CfgDataW-1:0] w_cfg_q, h_cfg_q;
  logic [KindW-1:0]    kind_q;
  logic [1:0]          rnd_q;
  logic [1:0]          rmod3_q;
  logic [IdxW-1:0]     qcell_q;
  logic [DirW-1:0]     qact_q;

  // maze state
  logic [SideW-1:0] mw_q, mh_q;
  logic [ProdW-1:0] prod_q;
  logic [CntW-1:0]  total_q;
  logic [CellW-1:0] clr_q;
  logic [CntW-1:0]  depth_q, visited_q;

  // carve scan
  logic [CellW-1:0]  cur_q, nb_q;
  logic [CoordW-1:0] curx_q, cury_q, nbx_q, nby_q;
  logic [1:0]        nb_idx_q;
  logic              rd_cur_q, rd_nb_q;
  logic [1:0]        rd_dir_q;
  logic [CellBits-1:0] cur_bits_q;
  logic [3:0]        avail_q;
  logic [DirW-1:0]   dir_q;

  // pending result and output register
  logic              res_carved_q, res_valid_q, res_open_q;
  logic [CellW-1:0]  res_from_q, res_to_q;
  logic [DirW-1:0]   res_dir_q;
  logic [PathW-1:0]  res_paths_q;

  logic [IdxW-1:0]   from_q, to_q;
  logic [DirW-1:0]   dir_out_q;
  logic              carved_q, done_q, open_q, valid_q;
  logic [PathW-1:0]  paths_q;

  // memory ports
  logic                cell_we, cell_re;
  logic [CellW-1:0]    cell_waddr, cell_raddr;
  logic [CellBits-1:0] cell_wdata, cell_rdata;
  logic                stk_we;
  logic [CellW-1:0]    stk_waddr, stk_raddr;
  logic [StkW-1:0]     stk_wdata, stk_rdata;

  logic [3:0]        inrange;
  logic [2:0]        nsum;
  logic [1:0]        ksel;
  logic [DirW-1:0]   sel_dir;
  logic [CellW-1:0]  scan_addr, sel_addr;
  logic [CoordW-1:0] sel_x, sel_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cfg_q <= GridSideReset;
      h_cfg_q <= GridSideReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegGridWidth) begin
        w_cfg_q <= cfg_data_i;
      end else if (cfg_index_i == RegGridHeight) begin
        h_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      rnd_q   <= random_word_i[1:0];
      rmod3_q <= mod3(random_word_i);
      qcell_q <= query_cell_i;
      qact_q  <= query_action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q      <= '0;
      mh_q      <= '0;
      total_q   <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      rd_cur_q  <= 1'b0;
      rd_nb_q   <= 1'b0;
    end else begin
      rd_cur_q <= cmd_i.rd_cur;
      rd_nb_q  <= cmd_i.rd_nb;
      if (cmd_i.size_load) begin
        mw_q <= clamp_side(w_cfg_q, 1'b1);
        mh_q <= clamp_side(h_cfg_q, 1'b0);
      end else if (cmd_i.h_dec) begin
        mh_q <= mh_q - SideW'(1);
      end
      if (cmd_i.total_load) begin
        total_q <= CntW'(prod_q);
      end
      if (cmd_i.init) begin
        depth_q   <= CntW'(1);
        visited_q <= CntW'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - CntW'(1);
      end else if (cmd_i.push) begin
        depth_q   <= depth_q + CntW'(1);
        visited_q <= visited_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.size_mul) begin
      prod_q <= ProdW'(mw_q) * ProdW'(mh_q);
    end
    if (cmd_i.total_load) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + CellW'(1);
    end
  end

  // neighbour geometry of the current cell
  assign inrange[DirNorth] = (SideW'(cury_q) + SideW'(1)) < mh_q;
  assign inrange[DirSouth] = cury_q != '0;
  assign inrange[DirEast]  = (SideW'(curx_q) + SideW'(1)) < mw_q;
  assign inrange[DirWest]  = curx_q != '0;

  function automatic logic [CellW-1:0] nb_addr(input logic [DirW-1:0] d,
                                               input logic [CellW-1:0] c,
                                               input logic [SideW-1:0] w);
    logic [CellW-1:0] a;
    unique case (d)
      DirNorth: a = c + CellW'(w);
      DirSouth: a = c - CellW'(w);
      DirEast:  a = c + CellW'(1);
      default:  a = c - CellW'(1);
    endcase
    return a;
  endfunction

  assign scan_addr = nb_addr(nb_idx_q, cur_q, mw_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_q    <= stk_rdata[CellW-1:0];
      curx_q   <= stk_rdata[CellW +: CoordW];
      cury_q   <= stk_rdata[CellW+CoordW +: CoordW];
      nb_idx_q <= '0;
    end else if (cmd_i.rd_nb) begin
      nb_idx_q <= nb_idx_q + 2'd1;
    end
    if (cmd_i.rd_nb) begin
      rd_dir_q <= nb_idx_q;
    end
    if (rd_cur_q) begin
      cur_bits_q <= cell_rdata;
    end
    if (rd_nb_q) begin
      avail_q[rd_dir_q] <= inrange[rd_dir_q] & ~cell_rdata[VisitedBit];
    end
  end

  // move selection
  assign nsum = 3'(avail_q[0]) + 3'(avail_q[1]) + 3'(avail_q[2]) + 3'(avail_q[3]);

  always_comb begin
    unique case (nsum)
      3'd1:    ksel = 2'd0;
      3'd2:    ksel = {1'b0, rnd_q[0]};
      3'd3:    ksel = rmod3_q;
      default: ksel = rnd_q[1:0];
    endcase
  end

  assign sel_dir  = pick(avail_q, ksel);
  assign sel_addr = nb_addr(sel_dir, cur_q, mw_q);

  always_comb begin
    sel_x = curx_q;
    sel_y = cury_q;
    unique case (sel_dir)
      DirNorth: sel_y = cury_q + CoordW'(1);
      DirSouth: sel_y = cury_q - CoordW'(1);
      DirEast:  sel_x = curx_q + CoordW'(1);
      default:  sel_x = curx_q - CoordW'(1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      dir_q <= sel_dir;
      nb_q  <= sel_addr;
      nbx_q <= sel_x;
      nby_q <= sel_y;
    end
  end

  // cell store
  always_comb begin
    cell_we    = cmd_i.clr_step | cmd_i.sel | cmd_i.push;
    cell_waddr = nb_q;
    cell_wdata = VisitedMask | CellBits'(PathW'(1) << (dir_q ^ DirW'(1)));
    priority if (cmd_i.clr_step) begin
      cell_waddr = clr_q;
      cell_wdata = (clr_q == '0) ? VisitedMask : '0;
    end else if (cmd_i.sel) begin
      cell_waddr = cur_q;
      cell_wdata = {cur_bits_q[VisitedBit], cur_bits_q[PathW-1:0] | (PathW'(1) << sel_dir)};
    end else begin
      cell_waddr = nb_q;
    end
  end

  always_comb begin
    cell_re = cmd_i.rd_cur | cmd_i.rd_nb | cmd_i.q_rd;
    priority if (cmd_i.rd_cur) begin
      cell_raddr = cur_q;
    end else if (cmd_i.rd_nb) begin
      cell_raddr = scan_addr;
    end else begin
      cell_raddr = CellW'(qcell_q);
    end
  end

  mbg_ram #(
    .Width(CellBits),
    .Depth(MaxCells)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_waddr),
    .wdata_i(cell_wdata),
    .re_i   (cell_re),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  // path stack: {row, column, index}
  assign stk_we    = cmd_i.init | cmd_i.push;
  assign stk_waddr = cmd_i.init ? '0 : depth_q[CellW-1:0];
  assign stk_wdata = cmd_i.init ? '0 : {nby_q, nbx_q, nb_q};
  assign stk_raddr = CellW'(depth_q - CntW'(1));

  mbg_ram #(
    .Width(StkW),
    .Depth(MaxCells)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (cmd_i.stk_rd),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_carved_q <= 1'b0;
      res_from_q   <= '0;
      res_to_q     <= '0;
      res_dir_q    <= DirNorth;
      res_valid_q  <= 1'b0;
      res_paths_q  <= '0;
      res_open_q   <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        res_carved_q <= 1'b1;
        res_from_q   <= cur_q;
        res_to_q     <= nb_q;
        res_dir_q    <= dir_q;
      end
      if (cmd_i.q_cap) begin
        res_valid_q <= 1'b1;
        res_paths_q <= cell_rdata[PathW-1:0];
        res_open_q  <= cell_rdata[{1'b0, qact_q}];
      end
    end
    if (cmd_i.out_load) begin
      from_q    <= IdxW'(res_from_q);
      to_q      <= IdxW'(res_to_q);
      dir_out_q <= res_dir_q;
      carved_q  <= res_carved_q;
      done_q    <= (total_q != '0) && (visited_q >= total_q);
      paths_q   <= res_paths_q;
      open_q    <= res_open_q;
      valid_q   <= res_valid_q;
    end
  end

  assign from_cell_o   = from_q;
  assign to_cell_o     = to_q;
  assign carve_dir_o   = dir_out_q;
  assign carved_o      = carved_q;
  assign done_res_o    = done_q;
  assign cell_paths_o  = paths_q;
  assign action_open_o = open_q;
  assign cell_valid_o  = valid_q;

  // status
  assign status_o.is_start   = kind_q == KindStart;
  assign status_o.is_carve   = kind_q == KindCarve;
  assign status_o.is_query   = kind_q == KindQuery;
  assign status_o.carve_ok   = (total_q != '0) && (visited_q < total_q);
  assign status_o.query_ok   = CmpW'(qcell_q) < CmpW'(total_q);
  assign status_o.prod_fits  = prod_q <= ProdW'(MaxCells);
  assign status_o.clr_last   = CntW'(clr_q) == (total_q - CntW'(1));
  assign status_o.depth_zero = depth_q == '0;
  assign status_o.nb_last    = nb_idx_q == 2'd3;
  assign status_o.nb_none    = avail_q == '0;

endmodule

[design/maze_backtracker_generator_top.sv]
// ----------------------------------------------------------------------------
// maze_backtracker_generator_top
// Depth-first backtracking maze generator with start, carve and query items.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | in
//  in      | in_valid_i/in_ready_o, kind, random_word,       | in
//          | query_cell, query_action                        |
//  out     | out_valid_o/out_ready_i, from_cell .. cell_valid | out
//
// One item at a time. A query reads one cell; an unused kind or refused
// carve goes straight to the result. A carve scans the stack top, popping
// dead ends (each scan reads the cell and its four neighbours through the
// single cell store read port). A start clears the cell store one grid
// cell per step, after cutting the height while the grid exceeds the store.
// A finished item waits in the output register; the next item is taken
// meanwhile and holds in its last state until that register frees.
// Reset leaves no maze; the cell store is cleared by each start.
// ----------------------------------------------------------------------------
module maze_backtracker_generator_top #(
  parameter int unsigned MaxCells = mbg_pkg::MaxCellsDef,
  parameter int unsigned MaxSide  = mbg_pkg::MaxSideDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mbg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mbg_pkg::KindW-1:0]     kind_i,
  input  logic [mbg_pkg::RandW-1:0]     random_word_i,
  input  logic [mbg_pkg::IdxW-1:0]      query_cell_i,
  input  logic [mbg_pkg::DirW-1:0]      query_action_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mbg_pkg::IdxW-1:0]      from_cell_o,
  output logic [mbg_pkg::IdxW-1:0]      to_cell_o,
  output logic [mbg_pkg::DirW-1:0]      carve_dir_o,
  output logic                          carved_o,
  output logic                          done_res_o,
  output logic [mbg_pkg::PathW-1:0]     cell_paths_o,
  output logic                          action_open_o,
  output logic                          cell_valid_o
);
  import mbg_pkg::*;

  mbg_cmd_t    cmd;
  mbg_status_t status;

  assign cfg_ready_o = 1'b1;

  mbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbg_dp #(
    .MaxCells(MaxCells),
    .MaxSide (MaxSide)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .random_word_i (random_word_i),
    .query_cell_i  (query_cell_i),
    .query_action_i(query_action_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .from_cell_o   (from_cell_o),
    .to_cell_o     (to_cell_o),
    .carve_dir_o   (carve_dir_o),
    .carved_o      (carved_o),
    .done_res_o    (done_res_o),
    .cell_paths_o  (cell_paths_o),
    .action_open_o (action_open_o),
    .cell_valid_o  (cell_valid_o)
  );

endmodule

[dv/tb_maze_backtracker_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_maze_backtracker_generator_top
// Self-checking bench for the backtracking maze generator. A queue-fed driver
// sends start, carve, query and spare-kind items over several grid settings,
// a predictor tracks the maze as items are taken, and a monitor compares
// every result field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_generator_top;
  import mbg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KindW-1:0]   KindSpare  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;
  localparam int unsigned        StallLimit = 40000;
  localparam int unsigned        RandomItems = 900;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [RandW-1:0] rnd;
    logic [IdxW-1:0]  qcell;
    logic [DirW-1:0]  qact;
  } maze_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  from_cell;
    logic [IdxW-1:0]  to_cell;
    logic [DirW-1:0]  carve_dir;
    logic             carved;
    logic             done_res;
    logic [PathW-1:0] cell_paths;
    logic             action_open;
    logic             cell_valid;
  } maze_result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [KindW-1:0]    kind_i         = '0;
  logic [RandW-1:0]    random_word_i  = '0;
  logic [IdxW-1:0]     query_cell_i   = '0;
  logic [DirW-1:0]     query_action_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [IdxW-1:0]     from_cell_o;
  logic [IdxW-1:0]     to_cell_o;
  logic [DirW-1:0]     carve_dir_o;
  logic                carved_o;
  logic                done_res_o;
  logic [PathW-1:0]    cell_paths_o;
  logic                action_open_o;
  logic                cell_valid_o;

  // maze tracking state
  logic [CfgDataW-1:0] reg_grid_w = GridSideReset;
  logic [CfgDataW-1:0] reg_grid_h = GridSideReset;
  logic [CellBits-1:0] maze_cells [MaxCellsDef];
  logic [IdxW-1:0]     trail [MaxCellsDef];
  int unsigned         trail_depth   = 0;
  int unsigned         visited_cells = 0;
  int unsigned         maze_w        = 0;
  int unsigned         maze_h        = 0;

  maze_item_t   items_to_send[$];
  maze_result_t maze_results_due[$];
  int unsigned  idle_pct     = 38;
  int unsigned  mismatches   = 0;
  int unsigned  stall_cycles = 0;

  maze_backtracker_generator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .random_word_i  (random_word_i),
    .query_cell_i   (query_cell_i),
    .query_action_i (query_action_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .from_cell_o    (from_cell_o),
    .to_cell_o      (to_cell_o),
    .carve_dir_o    (carve_dir_o),
    .carved_o       (carved_o),
    .done_res_o     (done_res_o),
    .cell_paths_o   (cell_paths_o),
    .action_open_o  (action_open_o),
    .cell_valid_o   (cell_valid_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_side(input logic [CfgDataW-1:0] v);
    if (v < 2) return 2;
    if (v > MaxSideDef) return MaxSideDef;
    return 32'(v);
  endfunction

  function automatic maze_result_t apply_maze_item(input maze_item_t it);
    maze_result_t    r;
    int unsigned     total;
    int unsigned     cur;
    int unsigned     x;
    int unsigned     y;
    int unsigned     n;
    int unsigned     nb;
    int unsigned     w;
    int unsigned     h;
    logic [DirW-1:0] opts [4];
    logic [DirW-1:0] d;
    bit              found;
    r = '0;
    total = maze_w * maze_h;
    case (it.kind)
      KindStart: begin
        w = clamp_side(reg_grid_w);
        h = clamp_side(reg_grid_h);
        if (w > MaxCellsDef) w = MaxCellsDef;
        if (w * h > MaxCellsDef) h = MaxCellsDef / w;
        maze_w = w;
        maze_h = h;
        foreach (maze_cells[i]) maze_cells[i] = '0;
        maze_cells[0] = VisitedMask;
        trail[0] = '0;
        trail_depth = 1;
        visited_cells = 1;
      end
      KindCarve: begin
        found = 1'b0;
        if (total != 0 && visited_cells < total) begin
          while (trail_depth > 0 && !found) begin
            cur = 32'(trail[IdxW'((trail_depth - 1) % MaxCellsDef)]);
            n = 0;
            if (cur < total) begin
              x = cur % maze_w;
              y = cur / maze_w;
              if (y + 1 < maze_h && !maze_cells[IdxW'(cur + maze_w)][VisitedBit]) begin
                opts[2'(n)] = DirNorth;
                n++;
              end
              if (y > 0 && !maze_cells[IdxW'(cur - maze_w)][VisitedBit]) begin
                opts[2'(n)] = DirSouth;
                n++;
              end
              if (x + 1 < maze_w && !maze_cells[IdxW'(cur + 1)][VisitedBit]) begin
                opts[2'(n)] = DirEast;
                n++;
              end
              if (x > 0 && !maze_cells[IdxW'(cur - 1)][VisitedBit]) begin
                opts[2'(n)] = DirWest;
                n++;
              end
            end
            if (n == 0) begin
              trail_depth--;
            end else begin
              d = opts[2'(32'(it.rnd) % n)];
              case (d)
                DirNorth: nb = cur + maze_w;
                DirSouth: nb = cur - maze_w;
                DirEast:  nb = cur + 1;
                default:  nb = cur - 1;
              endcase
              maze_cells[IdxW'(cur)][{1'b0, d}] = 1'b1;
              maze_cells[IdxW'(nb)][{1'b0, d ^ 2'd1}] = 1'b1;
              maze_cells[IdxW'(nb)][VisitedBit] = 1'b1;
              if (trail_depth < MaxCellsDef) begin
                trail[IdxW'(trail_depth)] = nb[IdxW-1:0];
                trail_depth++;
              end
              visited_cells++;
              r.from_cell = cur[IdxW-1:0];
              r.to_cell = nb[IdxW-1:0];
              r.carve_dir = d;
              r.carved = 1'b1;
              found = 1'b1;
            end
          end
        end
      end
      KindQuery: begin
        if (it.qcell < total && it.qcell < MaxCellsDef) begin
          r.cell_valid = 1'b1;
          r.cell_paths = maze_cells[it.qcell][PathW-1:0];
          r.action_open = r.cell_paths[it.qact];
        end
      end
      default: ;
    endcase
    r.done_res = (maze_w * maze_h != 0) && (visited_cells >= maze_w * maze_h);
    return r;
  endfunction

  // driver: takes prediction on acceptance, then offers the next item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        maze_results_due.push_back(apply_maze_item({kind_i, random_word_i, query_cell_i,
                                                    query_action_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          {kind_i, random_word_i, query_cell_i, query_action_i} <= items_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    maze_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (maze_results_due.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = maze_results_due.pop_front();
          check_field("from_cell", 32'(want.from_cell), 32'(from_cell_o));
          check_field("to_cell", 32'(want.to_cell), 32'(to_cell_o));
          check_field("carve_dir", 32'(want.carve_dir), 32'(carve_dir_o));
          check_field("carved", 32'(want.carved), 32'(carved_o));
          check_field("done_res", 32'(want.done_res), 32'(done_res_o));
          check_field("cell_paths", 32'(want.cell_paths), 32'(cell_paths_o));
          check_field("action_open", 32'(want.action_open), 32'(action_open_o));
          check_field("cell_valid", 32'(want.cell_valid), 32'(cell_valid_o));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_grid_reg(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegGridWidth:  reg_grid_w = val;
      RegGridHeight: reg_grid_h = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_item(input logic [KindW-1:0] kind, input logic [RandW-1:0] rnd,
                            input logic [IdxW-1:0] qcell, input logic [DirW-1:0] qact);
    items_to_send.push_back({kind, rnd, qcell, qact});
  endtask

  task automatic drain();
    while (items_to_send.size() != 0 || in_valid_i || maze_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    maze_item_t          it;
    int unsigned         sent;
    int unsigned         phase;
    int unsigned         span;
    int unsigned         count;
    int unsigned         roll;
    logic [CfgDataW-1:0] gw;
    logic [CfgDataW-1:0] gh;
    bit                  open_with_start;
    foreach (maze_cells[i]) maze_cells[i] = '0;
    foreach (trail[i]) trail[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no maze yet, then a 5x5 grid from the reset sizes
    queue_item(KindCarve, 16'h1234, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirNorth);
    queue_item(KindSpare, 16'hFFFF, 10'd1023, DirWest);
    queue_item(KindStart, 16'h0000, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirSouth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirEast);
    queue_item(KindQuery, 16'h0000, 10'd0, DirWest);
    queue_item(KindCarve, 16'h0000, 10'd0, DirNorth);
    queue_item(KindCarve, 16'hFFFF, 10'd0, DirNorth);
    queue_item(KindCarve, 16'h5555, 10'd0, DirNorth);
    queue_item(KindCarve, 16'hAAAA, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirEast);
    queue_item(KindQuery, 16'h0000, 10'd24, DirWest);
    queue_item(KindQuery, 16'h0000, 10'd25, DirSouth);
    queue_item(KindQuery, 16'hFFFF, 10'd1023, DirEast);
    queue_item(KindQuery, 16'h0000, 10'd5, DirSouth);
    queue_item(KindSpare, 16'h0000, 10'd0, DirNorth);
    queue_item(KindStart, 16'h0000, 10'd0, DirNorth);
    queue_item(KindCarve, 16'h8000, 10'd0, DirNorth);
    queue_item(KindQuery, 16'h0000, 10'd0, DirSouth);
    drain();

    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case (phase)
        0: begin gw = 6'd2;  gh = 6'd2;  end
        1: begin gw = 6'd0;  gh = 6'd1;  end
        2: begin gw = 6'd32; gh = 6'd32; end
        3: begin gw = 6'd63; gh = 6'd33; end
        4: begin gw = 6'd1;  gh = 6'd32; end
        5: begin gw = 6'd32; gh = 6'd2;  end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            gw = CfgDataW'($urandom_range(2, 8));
            gh = CfgDataW'($urandom_range(2, 8));
          end else begin
            gw = CfgDataW'($urandom_range(0, 63));
            gh = CfgDataW'($urandom_range(0, 63));
          end
        end
      endcase
      write_grid_reg(RegGridWidth, gw);
      write_grid_reg(RegGridHeight, gh);
      if (phase == 0 || $urandom_range(0, 4) == 0) begin
        write_grid_reg(RegSpareLo, CfgDataW'($urandom_range(0, 63)));
        write_grid_reg(RegSpareHi, CfgDataW'($urandom_range(0, 63)));
      end
      // without a start the new sizes wait and the old maze carries on
      open_with_start = (phase < 6) || ($urandom_range(0, 99) < 85);
      span = open_with_start ? clamp_side(gw) * clamp_side(gh) : maze_w * maze_h;
      if (span == 0) span = 25;
      count = span + span / 4 + 10;
      if (count > 160) count = 160;
      if (phase == 2) count = 300;
      idle_pct = (phase == 2) ? 0 : 38;
      if (open_with_start) begin
        queue_item(KindStart, RandW'($urandom_range(0, 65535)), 10'd0, DirNorth);
      end
      for (int unsigned i = 0; i < count; i++) begin
        it.rnd = RandW'($urandom_range(0, 65535));
        it.qact = DirW'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 80) begin
          it.qcell = IdxW'($urandom_range(0, span + 2 > 1023 ? 1023 : span + 2));
        end else begin
          it.qcell = IdxW'($urandom_range(0, 1023));
        end
        roll = $urandom_range(0, 99);
        if (roll < 72) it.kind = KindCarve;
        else if (roll < 92) it.kind = KindQuery;
        else if (roll < 96) it.kind = KindStart;
        else it.kind = KindSpare;
        items_to_send.push_back(it);
      end
      sent += count;
      drain();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/mbg_pkg.sv
design/mbg_ram.sv
design/mbg_ctrl.sv
design/mbg_dp.sv
design/maze_backtracker_generator_top.sv
dv/tb_maze_backtracker_generator_top.sv
